@@ rtl/ssc_pkg.sv @@
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared widths, codes and helpers for the start-signal countdown sequencer.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int TIMER_BITS = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_W       = 8;
  localparam int OUT_W      = 16;
  localparam int LINES_W    = 6;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [CFG_W-1:0]      cfg_t;
  typedef logic [LINES_W-1:0]    lines_t;
  typedef logic [2:0]            step_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_ALARM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOUL_ALARM  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_TONE  = 2'd3;

  // Output line bits
  localparam lines_t L_GREEN = 6'h01;
  localparam lines_t L_RED   = 6'h02;
  localparam lines_t L_SPK   = 6'h04;
  localparam lines_t L_READY = 6'h08;
  localparam lines_t L_ALARM = 6'h10;
  localparam lines_t L_START = 6'h20;

  // Segment patterns
  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_FIVE  = 8'hda;
  localparam logic [7:0] SEG_FOUR  = 8'hcc;
  localparam logic [7:0] SEG_THREE = 8'h9e;
  localparam logic [7:0] SEG_TWO   = 8'hb6;
  localparam logic [7:0] SEG_ONE   = 8'h0c;
  localparam logic [7:0] SEG_FAULT = 8'he2;

  // Countdown steps
  localparam step_t STEP_DIGIT4 = 3'd0;
  localparam step_t STEP_DIGIT3 = 3'd1;
  localparam step_t STEP_DIGIT2 = 3'd2;
  localparam step_t STEP_DIGIT1 = 3'd3;
  localparam step_t STEP_FAULT  = 3'd4;
  localparam step_t STEP_ALARM  = 3'd5;
  localparam step_t STEP_IDLE   = 3'd6;

  // Saturate a register value to the timer width
  function automatic timer_t clamp_timer(input cfg_t v);
    if (TIMER_BITS >= CFG_W) begin
      return timer_t'(v);
    end else if (|(v >> TIMER_BITS)) begin
      return '1;
    end else begin
      return timer_t'(v);
    end
  endfunction

  function automatic timer_t count_down(input timer_t t);
    return (t != '0) ? t - timer_t'(1) : '0;
  endfunction

endpackage

@@ rtl/start_signal_countdown_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// start_signal_countdown_sequencer_core
// Race starter controller: ready countdown, foul alarm, start tone, reset.
// ----------------------------------------------------------------------------
//
// Channel | Direction | Content
// --------+-----------+--------------------------------------------------------
// in_     | slave     | one tick item: ready, foul, start, reset levels
// out_    | master    | one result per tick: lamps, speaker, tones, segments
// cfg_    | write     | step, final alarm, foul alarm, start tone lengths
//
// Each item is processed combinationally: the flag and timer update sits
// between the accepted input and the result register; one item per cycle
// is sustained unless out_ stalls, and its result appears the next cycle.
// The input is taken whenever the result register is empty or being drained.
// A stall on out_ holds the result register and back-pressures in_tready.
// rst_n is synchronous, active low, and restores the power-up state and the
// default register values.
// ----------------------------------------------------------------------------
module start_signal_countdown_sequencer_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // in_tdata: [0] ready_in, [1] foul_in, [2] start_in, [3] reset_in, zero pad
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [ssc_pkg::IN_W-1:0]     in_tdata,
  // out_tdata: [0] green_lamp, [1] led_red, [2] speaker_power, [3] tone_ready,
  //   [4] tone_alarm, [5] tone_start, [13:6] segment_pattern,
  //   [14] segment_write, zero pad
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [ssc_pkg::OUT_W-1:0]    out_tdata,
  input  logic                         cfg_we,
  input  logic [ssc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [ssc_pkg::CFG_W-1:0]    cfg_wdata
);
  import ssc_pkg::*;

  // Configuration registers
  cfg_t step_ticks_r, final_alarm_r, foul_alarm_r, start_tone_r;

  // Controller state
  logic   armed_r, start_allowed_r, cd_active_r, foul_active_r, tone_active_r;
  logic   cd_fresh_r, foul_fresh_r, start_fresh_r;
  step_t  step_r;
  timer_t cd_timer_r, foul_timer_r, start_timer_r;
  lines_t lines_r;
  logic [7:0] seg_r;

  logic   armed_nxt, start_allowed_nxt, cd_active_nxt, foul_active_nxt, tone_active_nxt;
  logic   cd_fresh_nxt, foul_fresh_nxt, start_fresh_nxt;
  step_t  step_nxt;
  timer_t cd_timer_nxt, foul_timer_nxt, start_timer_nxt;
  lines_t lines_nxt;
  logic [7:0] seg_nxt;
  logic   seg_wr;

  // Result register
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  logic in_acc;
  logic rdy, foul, start, rst_btn;
  logic cd_exp, fl_exp, st_exp;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign rdy     = in_tdata[0];
  assign foul    = in_tdata[1];
  assign start   = in_tdata[2];
  assign rst_btn = in_tdata[3];

  // Hold configuration until written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ticks_r  <= CFG_W'(1000);
      final_alarm_r <= CFG_W'(4000);
      foul_alarm_r  <= CFG_W'(4000);
      start_tone_r  <= CFG_W'(1000);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_STEP_TICKS:  step_ticks_r  <= cfg_wdata;
        REG_FINAL_ALARM: final_alarm_r <= cfg_wdata;
        REG_FOUL_ALARM:  foul_alarm_r  <= cfg_wdata;
        REG_START_TONE:  start_tone_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // One tick: four branches in priority order, a later one overriding
  always_comb begin
    armed_nxt         = armed_r;
    start_allowed_nxt = start_allowed_r;
    cd_active_nxt     = cd_active_r;
    foul_active_nxt   = foul_active_r;
    tone_active_nxt   = tone_active_r;
    cd_fresh_nxt      = cd_fresh_r;
    foul_fresh_nxt    = foul_fresh_r;
    start_fresh_nxt   = start_fresh_r;
    step_nxt          = step_r;
    lines_nxt         = lines_r;
    seg_nxt           = seg_r;
    seg_wr            = 1'b0;

    // Sample expiry before the timers advance
    cd_exp = (cd_timer_r == '0);
    fl_exp = (foul_timer_r == '0);
    st_exp = (start_timer_r == '0);
    cd_timer_nxt    = count_down(cd_timer_r);
    foul_timer_nxt  = count_down(foul_timer_r);
    start_timer_nxt = count_down(start_timer_r);

    // Ready arms the countdown, otherwise advance it
    if (rdy && armed_r) begin
      start_allowed_nxt = 1'b1;
      cd_active_nxt     = 1'b1;
      armed_nxt         = 1'b0;
      lines_nxt         = (lines_nxt | L_GREEN | L_SPK | L_READY) & ~L_RED;
    end else if (cd_active_r) begin
      if (cd_fresh_r) begin
        seg_nxt      = SEG_FIVE;
        seg_wr       = 1'b1;
        cd_timer_nxt = clamp_timer(step_ticks_r);
        cd_exp       = 1'b0;
      end
      cd_fresh_nxt = 1'b0;
      if (cd_exp && step_r < STEP_IDLE) begin
        unique case (step_r)
          STEP_DIGIT4: begin
            lines_nxt    = lines_nxt & ~(L_READY | L_SPK);
            seg_nxt      = SEG_FOUR;
            cd_timer_nxt = clamp_timer(step_ticks_r);
          end
          STEP_DIGIT3: begin
            seg_nxt      = SEG_THREE;
            cd_timer_nxt = clamp_timer(step_ticks_r);
          end
          STEP_DIGIT2: begin
            seg_nxt      = SEG_TWO;
            cd_timer_nxt = clamp_timer(step_ticks_r);
          end
          STEP_DIGIT1: begin
            seg_nxt      = SEG_ONE;
            cd_timer_nxt = clamp_timer(step_ticks_r);
          end
          STEP_FAULT: begin
            lines_nxt         = (lines_nxt | L_SPK | L_ALARM | L_RED) & ~L_GREEN;
            seg_nxt           = SEG_FAULT;
            cd_timer_nxt      = clamp_timer(final_alarm_r);
            start_allowed_nxt = 1'b0;
          end
          default: begin
            lines_nxt     = lines_nxt & ~(L_SPK | L_ALARM);
            cd_active_nxt = 1'b0;
          end
        endcase
        if (step_r < STEP_ALARM) begin
          seg_wr = 1'b1;
        end
        step_nxt = step_r + step_t'(1);
      end
    end

    // Foul shows F and sounds the alarm; release starts its run-out timer
    if (foul) begin
      seg_nxt           = SEG_FAULT;
      seg_wr            = 1'b1;
      lines_nxt         = (lines_nxt | L_RED | L_SPK | L_ALARM) & ~L_GREEN;
      armed_nxt         = 1'b0;
      start_allowed_nxt = 1'b0;
      cd_active_nxt     = 1'b0;
      foul_active_nxt   = 1'b1;
      step_nxt          = STEP_IDLE;
    end else if (foul_active_r) begin
      if (foul_fresh_r) begin
        foul_timer_nxt = clamp_timer(foul_alarm_r);
        fl_exp         = 1'b0;
      end
      foul_fresh_nxt = 1'b0;
      if (fl_exp) begin
        lines_nxt       = lines_nxt & ~(L_ALARM | L_SPK);
        foul_active_nxt = 1'b0;
        foul_fresh_nxt  = 1'b1;
      end
    end

    // Start sounds the start tone while permitted
    if (start && start_allowed_nxt) begin
      lines_nxt         = (lines_nxt | L_SPK | L_START | L_GREEN) & ~L_RED;
      start_allowed_nxt = 1'b0;
      cd_active_nxt     = 1'b0;
      tone_active_nxt   = 1'b1;
      step_nxt          = STEP_IDLE;
    end else if (tone_active_r) begin
      if (start_fresh_r) begin
        start_timer_nxt = clamp_timer(start_tone_r);
        st_exp          = 1'b0;
      end
      start_fresh_nxt = 1'b0;
      if (st_exp) begin
        lines_nxt       = lines_nxt & ~(L_START | L_SPK);
        tone_active_nxt = 1'b0;
      end
    end

    // Reset button clears the display and lines and re-arms
    if (rst_btn) begin
      armed_nxt         = 1'b1;
      start_allowed_nxt = 1'b0;
      cd_active_nxt     = 1'b0;
      cd_fresh_nxt      = 1'b1;
      foul_fresh_nxt    = 1'b1;
      start_fresh_nxt   = 1'b1;
      step_nxt          = STEP_DIGIT4;
      seg_nxt           = SEG_BLANK;
      seg_wr            = 1'b1;
      lines_nxt         = '0;
    end
  end

  // Advance state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r         <= 1'b1;
      start_allowed_r <= 1'b0;
      cd_active_r     <= 1'b0;
      foul_active_r   <= 1'b0;
      tone_active_r   <= 1'b0;
      cd_fresh_r      <= 1'b1;
      foul_fresh_r    <= 1'b1;
      start_fresh_r   <= 1'b1;
      step_r          <= STEP_DIGIT4;
      cd_timer_r      <= '0;
      foul_timer_r    <= '0;
      start_timer_r   <= '0;
      lines_r         <= '0;
      seg_r           <= SEG_BLANK;
    end else if (in_acc) begin
      armed_r         <= armed_nxt;
      start_allowed_r <= start_allowed_nxt;
      cd_active_r     <= cd_active_nxt;
      foul_active_r   <= foul_active_nxt;
      tone_active_r   <= tone_active_nxt;
      cd_fresh_r      <= cd_fresh_nxt;
      foul_fresh_r    <= foul_fresh_nxt;
      start_fresh_r   <= start_fresh_nxt;
      step_r          <= step_nxt;
      cd_timer_r      <= cd_timer_nxt;
      foul_timer_r    <= foul_timer_nxt;
      start_timer_r   <= start_timer_nxt;
      lines_r         <= lines_nxt;
      seg_r           <= seg_nxt;
    end
  end

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= OUT_W'({seg_wr, seg_nxt, lines_nxt});
    end
  end

endmodule

@@ rtl/ssc_checker.sv @@
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks for the start-signal countdown sequencer.
// ----------------------------------------------------------------------------
module ssc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [ssc_pkg::IN_W-1:0]      in_tdata,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [ssc_pkg::OUT_W-1:0]     out_tdata
);
  import ssc_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Every accepted item yields a result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted item gave no result");

  // Reset button blanks the display and clears every line
  a_reset_btn: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[3] |=> out_tdata[14:0] == 15'h4000)
    else $error("reset button did not clear outputs");

  // Foul without reset writes F to the display
  a_foul_seg: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[1] && !in_tdata[3]
      |=> out_tdata[13:6] == SEG_FAULT && out_tdata[14] && out_tdata[1])
    else $error("foul did not show F");

endmodule

bind start_signal_countdown_sequencer_core ssc_checker u_ssc_checker (.*);

@@ verif/ssc_panel_checker.sv @@
// ----------------------------------------------------------------------------
// ssc_panel_checker
// Watches the tick, result and register ports of the starter core, keeps its
// own copy of the starter state, predicts the lamp/tone/display panel for
// every accepted tick and compares it with each accepted result in order.
// ----------------------------------------------------------------------------
module ssc_panel_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [ssc_pkg::IN_W-1:0]      in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [ssc_pkg::OUT_W-1:0]     out_tdata,
  input  logic                          cfg_we,
  input  logic [ssc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [ssc_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            outstanding,
  output int                            results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import ssc_pkg::*;

  // Tick level positions in in_tdata
  localparam int BIT_READY = 0;
  localparam int BIT_FOUL  = 1;
  localparam int BIT_START = 2;
  localparam int BIT_RESET = 3;

  localparam cfg_t DEF_STEP  = 16'd1000;
  localparam cfg_t DEF_FINAL = 16'd4000;
  localparam cfg_t DEF_FOUL  = 16'd4000;
  localparam cfg_t DEF_TONE  = 16'd1000;

  localparam int MAX_LINES = 100;

  typedef struct packed {
    logic       seg_wr;
    logic [7:0] seg;
    lines_t     lines;
  } panel_t;

  string line_name [LINES_W] = '{"green_lamp", "led_red", "speaker_power",
                                 "tone_ready", "tone_alarm", "tone_start"};

  panel_t panel_expect_q [$];

  cfg_t   step_len, final_len, foul_len, tone_len;
  logic   armed, start_ok, cd_active, alarm_on, tone_on;
  logic   cd_fresh, foul_fresh, tone_fresh;
  step_t  cd_step;
  timer_t cd_tmr, foul_tmr, tone_tmr;
  lines_t lines;
  logic [7:0] shown;

  int n_fail = 0;
  int n_results = 0;
  int lines_printed = 0;

  // Saturate a register value to the timer width
  function automatic timer_t load_timer(input cfg_t v);
    longint unsigned top_v;
    top_v = (64'd1 << TIMER_BITS) - 64'd1;
    return (longint'(v) > top_v) ? timer_t'(top_v) : timer_t'(v);
  endfunction

  function automatic timer_t tick_down(input timer_t t);
    return (t != '0) ? t - timer_t'(1) : t;
  endfunction

  task automatic note_field(input string field, input logic [7:0] want_v,
                            input logic [7:0] got_v);
    if (lines_printed < MAX_LINES)
      $display("%0t: %s expected %0h actual %0h", $time, field, want_v, got_v);
    lines_printed++;
  endtask

  // One millisecond tick: the four branches in fixed order, later ones win
  task automatic advance_starter(input logic [IN_W-1:0] word, output panel_t res);
    logic rdy, foul, go, clr, seg_wr, cd_exp, fl_exp, st_exp;
    lines_t ln;
    logic [7:0] seg;
    rdy    = word[BIT_READY];
    foul   = word[BIT_FOUL];
    go     = word[BIT_START];
    clr    = word[BIT_RESET];
    seg_wr = 1'b0;
    ln     = lines;
    seg    = shown;

    // expiry is judged on the value before this tick's count
    cd_exp   = (cd_tmr == '0);
    fl_exp   = (foul_tmr == '0);
    st_exp   = (tone_tmr == '0);
    cd_tmr   = tick_down(cd_tmr);
    foul_tmr = tick_down(foul_tmr);
    tone_tmr = tick_down(tone_tmr);

    if (rdy && armed) begin
      start_ok  = 1'b1;
      cd_active = 1'b1;
      armed     = 1'b0;
      ln = (ln | L_GREEN | L_SPK | L_READY) & ~L_RED;
    end else if (cd_active) begin
      if (cd_fresh) begin
        seg    = SEG_FIVE;
        seg_wr = 1'b1;
        cd_tmr = load_timer(step_len);
        cd_exp = 1'b0;
      end
      cd_fresh = 1'b0;
      if (cd_exp && cd_step < STEP_IDLE) begin
        case (cd_step)
          STEP_DIGIT4: begin
            ln &= ~(L_READY | L_SPK);
            seg    = SEG_FOUR;
            cd_tmr = load_timer(step_len);
          end
          STEP_DIGIT3: begin
            seg    = SEG_THREE;
            cd_tmr = load_timer(step_len);
          end
          STEP_DIGIT2: begin
            seg    = SEG_TWO;
            cd_tmr = load_timer(step_len);
          end
          STEP_DIGIT1: begin
            seg    = SEG_ONE;
            cd_tmr = load_timer(step_len);
          end
          STEP_FAULT: begin
            ln = (ln | L_SPK | L_ALARM | L_RED) & ~L_GREEN;
            seg      = SEG_FAULT;
            cd_tmr   = load_timer(final_len);
            start_ok = 1'b0;
          end
          default: begin
            ln &= ~(L_SPK | L_ALARM);
            cd_active = 1'b0;
          end
        endcase
        if (cd_step < STEP_ALARM) seg_wr = 1'b1;
        cd_step = cd_step + step_t'(1);
      end
    end

    if (foul) begin
      seg    = SEG_FAULT;
      seg_wr = 1'b1;
      ln = (ln | L_RED | L_SPK | L_ALARM) & ~L_GREEN;
      armed     = 1'b0;
      start_ok  = 1'b0;
      cd_active = 1'b0;
      alarm_on  = 1'b1;
      cd_step   = STEP_IDLE;
    end else if (alarm_on) begin
      if (foul_fresh) begin
        foul_tmr = load_timer(foul_len);
        fl_exp   = 1'b0;
      end
      foul_fresh = 1'b0;
      if (fl_exp) begin
        ln &= ~(L_ALARM | L_SPK);
        alarm_on   = 1'b0;
        foul_fresh = 1'b1;
      end
    end

    if (go && start_ok) begin
      ln = (ln | L_SPK | L_START | L_GREEN) & ~L_RED;
      start_ok  = 1'b0;
      cd_active = 1'b0;
      tone_on   = 1'b1;
      cd_step   = STEP_IDLE;
    end else if (tone_on) begin
      if (tone_fresh) begin
        tone_tmr = load_timer(tone_len);
        st_exp   = 1'b0;
      end
      tone_fresh = 1'b0;
      if (st_exp) begin
        ln &= ~(L_START | L_SPK);
        tone_on = 1'b0;
      end
    end

    // running foul alarm and start tone are left alone by reset
    if (clr) begin
      armed      = 1'b1;
      start_ok   = 1'b0;
      cd_active  = 1'b0;
      cd_fresh   = 1'b1;
      foul_fresh = 1'b1;
      tone_fresh = 1'b1;
      cd_step    = STEP_DIGIT4;
      seg        = SEG_BLANK;
      seg_wr     = 1'b1;
      ln         = '0;
    end

    lines      = ln;
    shown      = seg;
    res.lines  = ln;
    res.seg    = seg;
    res.seg_wr = seg_wr;
  endtask

  always @(posedge clk) begin : watch
    panel_t got, want, nxt;
    logic bad;
    if (!rst_n) begin
      step_len   = DEF_STEP;
      final_len  = DEF_FINAL;
      foul_len   = DEF_FOUL;
      tone_len   = DEF_TONE;
      armed      = 1'b1;
      start_ok   = 1'b0;
      cd_active  = 1'b0;
      alarm_on   = 1'b0;
      tone_on    = 1'b0;
      cd_fresh   = 1'b1;
      foul_fresh = 1'b1;
      tone_fresh = 1'b1;
      cd_step    = STEP_DIGIT4;
      cd_tmr     = '0;
      foul_tmr   = '0;
      tone_tmr   = '0;
      lines      = '0;
      shown      = SEG_BLANK;
      panel_expect_q.delete();
    end else begin
      // compare first: a result always belongs to an earlier tick
      if (out_tvalid && out_tready) begin
        n_results++;
        // out_tdata: [5:0] lines, [13:6] segment byte, [14] segment write
        got.lines  = out_tdata[5:0];
        got.seg    = out_tdata[13:6];
        got.seg_wr = out_tdata[14];
        if (panel_expect_q.size() == 0) begin
          n_fail++;
          if (lines_printed < MAX_LINES)
            $display("%0t: result %0h arrived with no tick waiting", $time, out_tdata);
          lines_printed++;
        end else begin
          want = panel_expect_q.pop_front();
          bad  = 1'b0;
          for (int b = 0; b < LINES_W; b++) begin
            if (got.lines[b] !== want.lines[b]) begin
              bad = 1'b1;
              note_field(line_name[b], want.lines[b], got.lines[b]);
            end
          end
          if (got.seg !== want.seg) begin
            bad = 1'b1;
            note_field("segment_pattern", want.seg, got.seg);
          end
          if (got.seg_wr !== want.seg_wr) begin
            bad = 1'b1;
            note_field("segment_write", want.seg_wr, got.seg_wr);
          end
          if (bad) n_fail++;
        end
      end

      if (in_tvalid && in_tready) begin
        advance_starter(in_tdata, nxt);
        panel_expect_q.push_back(nxt);
      end

      if (cfg_we) begin
        case (cfg_addr)
          REG_STEP_TICKS:  step_len  = cfg_wdata;
          REG_FINAL_ALARM: final_len = cfg_wdata;
          REG_FOUL_ALARM:  foul_len  = cfg_wdata;
          REG_START_TONE:  tone_len  = cfg_wdata;
          default: ;
        endcase
      end
    end
    fail_count   <= n_fail;
    outstanding  <= panel_expect_q.size();
    results_seen <= n_results;
  end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the race starter core with millisecond tick items: a directed pass
// over the countdown, foul, start and reset cases, then random race sequences
// under several timer settings and three handshake idling profiles. The
// panel checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssc_pkg::*;

  // Tick levels as packed into in_tdata
  localparam logic [3:0] T_NONE  = 4'b0000;
  localparam logic [3:0] T_READY = 4'b0001;
  localparam logic [3:0] T_FOUL  = 4'b0010;
  localparam logic [3:0] T_START = 4'b0100;
  localparam logic [3:0] T_RESET = 4'b1000;
  localparam logic [3:0] T_ALL   = 4'b1111;

  localparam int PHASES      = 9;
  localparam int PHASE_TICKS = 170;
  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = 5;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata  = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr  = REG_STEP_TICKS;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int fail_count, outstanding, results_seen;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int ticks_sent    = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;

  start_signal_countdown_sequencer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  ssc_panel_checker u_panel_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: drop tready at random, one decision per cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: abort when neither channel has moved an item for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles", QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one tick item and hold it until the core takes it. An idle gap,
  // when drawn, drops tvalid for a cycle first; otherwise tvalid stays high
  // straight into the next item.
  task automatic send_tick(input logic [3:0] levels);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(levels);
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
  endtask

  // Hold the sender off until every tick has produced its result
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input cfg_t value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Registers change only once the core has drained
  task automatic apply_timing(input cfg_t step_len, input cfg_t final_len,
                              input cfg_t foul_len, input cfg_t tone_len);
    settle();
    write_reg(REG_STEP_TICKS,  step_len);
    write_reg(REG_FINAL_ALARM, final_len);
    write_reg(REG_FOUL_ALARM,  foul_len);
    write_reg(REG_START_TONE,  tone_len);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // One race: re-arm, press ready, then let the countdown run with the odd
  // start, foul, reset or random noise dropped in along the way
  task automatic run_race();
    int pick;
    if ($urandom_range(99) < 90) send_tick(T_RESET);
    else send_tick(4'($urandom_range(15)));
    repeat ($urandom_range(0, 2)) send_tick(T_NONE);
    repeat ($urandom_range(1, 3)) send_tick(T_READY);
    repeat ($urandom_range(5, 80)) begin
      pick = $urandom_range(99);
      if (pick < 3) send_tick(T_START);
      else if (pick < 5) repeat ($urandom_range(1, 4)) send_tick(T_FOUL);
      else if (pick < 7) send_tick(T_RESET);
      else if (pick < 15) send_tick(4'($urandom_range(15)));
      else send_tick(T_NONE);
    end
  endtask

  initial begin : stimulus
    int target;
    send_idle_pct = 6;
    recv_idle_pct = 50;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Power-up register values: ready lights the panel, then digit five
    send_tick(T_READY);
    send_tick(T_NONE);
    send_tick(T_RESET);

    // Shortest periods so that a whole countdown fits in a few ticks
    apply_timing(16'd1, 16'd1, 16'd1, 16'd1);
    send_tick(T_RESET);
    send_tick(T_READY);
    // walk five digits and F
    repeat (12) send_tick(T_NONE);
    // ready while not armed and start after permission has lapsed
    send_tick(T_READY | T_START);
    send_tick(T_RESET);
    send_tick(T_READY);
    // start mid-countdown, then reset while the start tone runs
    send_tick(T_START);
    send_tick(T_RESET);
    send_tick(T_NONE);
    send_tick(T_READY);
    // foul mid-countdown, release, re-assert during its alarm, release
    send_tick(T_FOUL);
    send_tick(T_NONE);
    send_tick(T_FOUL);
    send_tick(T_NONE);
    send_tick(T_NONE);
    send_tick(T_ALL);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 6;
        recv_idle_pct = 50;
      end else if (ph < 6) begin
        send_idle_pct = 50;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: apply_timing(16'd2, 16'd3, 16'd2, 16'd3);
        1: apply_timing(16'd1, 16'd1, 16'd1, 16'd1);
        3: apply_timing(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        5: apply_timing(16'd3, 16'd1, 16'd6, 16'd2);
        7: apply_timing(16'd1, 16'hffff, 16'd1, 16'hffff);
        default: apply_timing(cfg_t'($urandom_range(1, 8)), cfg_t'($urandom_range(1, 8)),
                              cfg_t'($urandom_range(1, 8)), cfg_t'($urandom_range(1, 8)));
      endcase
      target = ticks_sent + PHASE_TICKS;
      run_race();
      // hold the sender back once per phase until all results are in
      settle();
      while (ticks_sent < target) run_race();
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Drove %0d ticks through %0d timer settings; %0d results checked",
             ticks_sent, settings_used, results_seen);
    $display("Races covered countdown, foul, start and reset under three idling mixes");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d results mismatched", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
